// ===== design/sdtq_pkg.sv =====
// shared constants, types and helpers for the sorted deadline timer queue
package sdtq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 8;
   localparam int PERIOD_W    = 16;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 8;

   // operation codes carried on req_tuser
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // result status codes carried on rsp_tuser
   localparam logic [STATUS_W-1:0] STATUS_EXPIRED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_STARTED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic                capture;   // latch id and compute deadline of a start item
      logic                advance;   // one time tick
      logic                insert;    // sorted insert of the captured timer
      logic                pop;       // remove the head entry
      logic                load_out;  // load the result register
      logic [STATUS_W-1:0] status;
      logic                last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic head_due;
      logic next_due;
      logic out_free;
   } sts_type;

   // true when time a is at or after time b, wrap-aware
   function automatic logic not_before(input logic [TIME_WIDTH-1:0] a,
                                       input logic [TIME_WIDTH-1:0] b);
      logic [TIME_WIDTH-1:0] diff;
      diff = a - b;
      return ~diff[TIME_WIDTH-1];
   endfunction

endpackage

// ===== design/sorted_deadline_timer_queue.sv =====
// top level of the sorted deadline timer queue
// start item: its deadline is captured as it is accepted, and its result is loaded once the result register is free
// tick item: the counter advances as the item is accepted, then one expired timer is popped
//   at a time until the head is not due, each pop waiting for a free result register
// one item is worked on at a time; each expiry is done by the single head pop
// a stalled result holds the controller; the next item is taken while a result waits
// synchronous active-high reset clears the tick counter, fill count, result valid and controller state
module sorted_deadline_timer_queue
   import sdtq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] timer_id, [23:8] period
   input  logic                  req_tuser,   // [0] operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] result_id
   output logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   output logic                  rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   // controller
   sdtq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   sdtq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/sdtq_ctrl.sv =====
// controller state machine for the sorted deadline timer queue
module sdtq_ctrl
   import sdtq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    req_op,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_START = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.status   = STATUS_EXPIRED;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == OP_START) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_START;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_START: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.last     = 1'b1;
               cmd.insert   = ~sts.full;
               cmd.status   = sts.full ? STATUS_REJECTED : STATUS_STARTED;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!sts.head_due) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.pop      = 1'b1;
               cmd.load_out = 1'b1;
               cmd.status   = STATUS_EXPIRED;
               cmd.last     = ~sts.next_due;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/sdtq_dpath.sv =====
// datapath: tick counter, sorted timer array and result register
module sdtq_dpath
   import sdtq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [TIME_WIDTH-1:0] new_dl_ff, new_dl_in;
   logic [ID_W-1:0]       new_id_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TIME_WIDTH-1:0] entry_deadline_ff [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0] entry_deadline_in [QUEUE_DEPTH];
   logic [ID_W-1:0]       entry_id_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]       entry_id_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] before_new;
   logic [CNT_W-1:0]      ins_pos;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic                  rsp_last_ff;
   logic [ID_W-1:0]       period_id;
   logic [PERIOD_W-1:0]   period;

   assign period_id = req_tdata[ID_W-1:0];
   assign period    = req_tdata[ID_W+PERIOD_W-1:ID_W];

   // tick counter and captured start item
   assign now_in    = cmd.advance ? now_ff + TIME_WIDTH'(1) : now_ff;
   assign new_dl_in = now_ff + TIME_WIDTH'(period);

   // status toward the controller
   assign sts.full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign sts.head_due = (count_ff != '0) && not_before(now_ff, entry_deadline_ff[0]);
   assign sts.next_due = (count_ff > CNT_W'(1)) && not_before(now_ff, entry_deadline_ff[1]);
   assign sts.out_free = ~rsp_valid_ff | rsp_tready;

   // entries that stay ahead of the new timer (equal deadlines stay ahead)
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         before_new[i] = (CNT_W'(i) < count_ff) &&
                         not_before(new_dl_ff, entry_deadline_ff[i]);
      end
   end

   // first slot not ahead of the new timer
   always_comb begin
      ins_pos = count_ff;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!before_new[i]) begin
            ins_pos = CNT_W'(i);
         end
      end
   end

   // next contents of the sorted array: shift up on insert, down on pop
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         entry_deadline_in[i] = entry_deadline_ff[i];
         entry_id_in[i]       = entry_id_ff[i];
         if (cmd.insert) begin
            if (CNT_W'(i) == ins_pos) begin
               entry_deadline_in[i] = new_dl_ff;
               entry_id_in[i]       = new_id_ff;
            end else if (CNT_W'(i) > ins_pos && i != 0) begin
               entry_deadline_in[i] = entry_deadline_ff[i-1];
               entry_id_in[i]       = entry_id_ff[i-1];
            end
         end else if (cmd.pop && i != QUEUE_DEPTH - 1) begin
            entry_deadline_in[i] = entry_deadline_ff[i+1];
            entry_id_in[i]       = entry_id_ff[i+1];
         end
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_dl_ff <= new_dl_in;
         new_id_ff <= period_id;
      end
      entry_deadline_ff <= entry_deadline_in;
      entry_id_ff       <= entry_id_in;
      if (cmd.load_out) begin
         rsp_status_ff <= cmd.status;
         rsp_id_ff     <= (cmd.status == STATUS_EXPIRED) ? entry_id_ff[0] : new_id_ff;
         rsp_last_ff   <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !sts.full)
      else $error("insert into a full queue");

   a_pop_due: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> sts.head_due)
      else $error("pop of an entry that is not due");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result register overwritten while held");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> count_ff == $past(count_ff - CNT_W'(1)))
      else $error("fill count not decremented on pop");

endmodule
